// ===== hw/rtl/htfp_pkg.sv =====
//------------------------------------------------------------------------------
// htfp_pkg
// Shared types, codes and a helper function of the hex text frame parser.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htfp_pkg;

  // Input item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_IDLE = 1'b1;

  // Configuration register indexes
  localparam logic REG_EXP_CMD = 1'b0;
  localparam logic REG_EXP_LEN = 1'b1;

  // Result status codes
  localparam logic [2:0] STAT_RESP   = 3'd0;
  localparam logic [2:0] STAT_NOTE   = 3'd1;
  localparam logic [2:0] STAT_TRUNC  = 3'd2;
  localparam logic [2:0] STAT_BADCMD = 3'd3;
  localparam logic [2:0] STAT_BADIR  = 3'd4;

  // Command codes
  localparam logic [7:0] CMD_IR     = 8'h03;
  localparam logic [7:0] CMD_N04    = 8'h04;
  localparam logic [7:0] CMD_N0A    = 8'h0A;
  localparam logic [7:0] CMD_N0C    = 8'h0C;
  localparam logic [7:0] CMD_SINGLE = 8'h1A;
  localparam logic [7:0] CMD_N1D    = 8'h1D;
  localparam logic [7:0] CMD_PAIR   = 8'h79;
  localparam logic [7:0] CMD_N81    = 8'h81;

  // IR length byte limits
  localparam logic [7:0] IR_LEN_MIN = 8'd2;
  localparam logic [7:0] IR_LEN_MAX = 8'd4;

  // Parser controller states
  typedef enum logic [2:0] {
    PS_AWAIT,
    PS_COLLECT,
    PS_IRLEN,
    PS_DISCARD,
    PS_EMIT
  } parse_state_t;

  // Class of a command byte
  typedef enum logic [1:0] {
    CC_RESP,
    CC_NOTE,
    CC_IR,
    CC_BAD
  } cmd_class_t;

  // Source of the next output transaction
  typedef enum logic [2:0] {
    OS_NONE,
    OS_BADCMD,
    OS_BADIR,
    OS_TRUNC,
    OS_FRAME
  } out_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     nib_take;
    logic     nib_clear;
    logic     frame_start;
    logic     irlen_load;
    logic     collect;
    logic     count_clear;
    logic     emit_start;
    logic     emit_step;
    out_sel_t out_sel;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       nib_pending;
    cmd_class_t cmd_cls;
    logic       single;
    logic       len_ok;
    logic       frame_done;
    logic       emit_last;
    logic       out_free;
  } dp_stat_t;

  // ASCII hex digit to nibble, anything else is zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n = 4'(c - 8'h37);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hex_text_frame_parser.sv =====
// Output: an error or truncation transaction appears the cycle after its input;
//   a frame run passes through the emit state and then the output register, and gives one result
//   per cycle while the output register is free. Input: one character per cycle outside frame
//   runs while the output register drains; input is held off while a frame run goes out.
// Reset: synchronous, active high; control state and config registers return to defaults,
//   the frame store is not cleared (every entry read is written in the same frame).
//------------------------------------------------------------------------------
// hex_text_frame_parser
// Pairs ASCII hex characters into bytes, frames them by command and emits runs.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hex_text_frame_parser #(
  parameter int MAX_FRAME_LEN = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_addr,
  input  wire logic [7:0]  cfg_wdata,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_value
  input  wire logic        s_tuser,   // [0] kind
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [7:0] command, [15:8] data_byte,
                                      // [19:16] byte_index, [51:20] ir_code
  output logic [2:0]       m_tuser,   // [2:0] status
  output logic             m_tlast
);

  htfp_pkg::ctl_cmd_t ctl;
  htfp_pkg::dp_stat_t st;

  htfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .st       (st),
    .ctl      (ctl)
  );

  htfp_datapath #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .ctl       (ctl),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/htfp_datapath.sv =====
//------------------------------------------------------------------------------
// htfp_datapath
// Nibble pairing, command decode, frame store, counters and output register.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htfp_datapath #(
  parameter int MAX_FRAME_LEN = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_addr,
  input  wire logic [7:0]          cfg_wdata,
  // input character
  input  wire logic [7:0]          s_tdata,
  // controller
  input  wire htfp_pkg::ctl_cmd_t  ctl,
  output htfp_pkg::dp_stat_t       st,
  // output register
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [55:0]              m_tdata,
  output logic [2:0]               m_tuser,
  output logic                     m_tlast
);

  localparam int FRAME_CAP = (MAX_FRAME_LEN < 16) ? MAX_FRAME_LEN : 16;
  localparam int IDX_W = $clog2(FRAME_CAP);
  localparam logic [4:0] CAP5 = 5'(FRAME_CAP);

  // configuration registers
  logic [7:0] expected_command;
  logic [4:0] expected_length;

  // parse state
  logic [3:0]       nibble_hold;
  logic             nibble_pending;
  logic [7:0]       cmd_reg;
  logic [7:0]       frame_store [FRAME_CAP];
  logic [4:0]       byte_count;
  logic [4:0]       target_count;
  logic             is_response;
  logic [31:0]      ir_acc;
  logic [IDX_W-1:0] emit_idx;

  // decode
  logic [7:0]              cur_byte;
  logic [4:0]              resp_len;
  logic [4:0]              new_target;
  htfp_pkg::cmd_class_t    cls;
  logic                    emit_last;
  logic                    ir_frame;

  // output fields
  logic [7:0]  o_command;
  logic [7:0]  o_data;
  logic [3:0]  o_index;
  logic [31:0] o_ir;

  assign cur_byte = {nibble_hold, htfp_pkg::hex_nibble(s_tdata)};

  // response length clipped to 1..cap
  always_comb begin
    resp_len = expected_length;
    if (expected_length == 5'd0) begin
      resp_len = 5'd1;
    end else if (expected_length > CAP5) begin
      resp_len = CAP5;
    end
  end

  // command class and frame length
  always_comb begin
    cls        = htfp_pkg::CC_BAD;
    new_target = 5'd1;
    if (expected_command != 8'd0 && cur_byte == expected_command) begin
      cls        = htfp_pkg::CC_RESP;
      new_target = resp_len;
    end else begin
      case (cur_byte)
        htfp_pkg::CMD_N0C, htfp_pkg::CMD_N0A, htfp_pkg::CMD_N1D,
        htfp_pkg::CMD_N81, htfp_pkg::CMD_N04: begin
          cls        = htfp_pkg::CC_NOTE;
          new_target = 5'd2;
        end
        htfp_pkg::CMD_SINGLE: begin
          cls        = htfp_pkg::CC_NOTE;
          new_target = 5'd1;
        end
        htfp_pkg::CMD_PAIR: begin
          cls        = htfp_pkg::CC_NOTE;
          new_target = 5'd3;
        end
        htfp_pkg::CMD_IR: begin
          cls = htfp_pkg::CC_IR;
        end
        default: begin
          cls = htfp_pkg::CC_BAD;
        end
      endcase
    end
  end

  assign emit_last = ((5'(emit_idx) + 5'd1) == target_count);
  assign ir_frame  = !is_response && (cmd_reg == htfp_pkg::CMD_IR);

  // status to controller
  always_comb begin
    st.nib_pending = nibble_pending;
    st.cmd_cls     = cls;
    st.single      = (new_target == 5'd1);
    st.len_ok      = (cur_byte >= htfp_pkg::IR_LEN_MIN) && (cur_byte <= htfp_pkg::IR_LEN_MAX);
    st.frame_done  = ((byte_count + 5'd1) >= target_count);
    st.emit_last   = emit_last;
    st.out_free    = !m_tvalid || m_tready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= 8'd0;
      expected_length  <= 5'd1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        htfp_pkg::REG_EXP_CMD: expected_command <= cfg_wdata;
        htfp_pkg::REG_EXP_LEN: expected_length  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // nibble pairing
  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_hold    <= 4'd0;
      nibble_pending <= 1'b0;
    end else if (ctl.nib_clear) begin
      nibble_hold    <= 4'd0;
      nibble_pending <= 1'b0;
    end else if (ctl.nib_take) begin
      if (!nibble_pending) begin
        nibble_hold <= htfp_pkg::hex_nibble(s_tdata);
      end
      nibble_pending <= !nibble_pending;
    end
  end

  // frame counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= 5'd0;
      target_count <= 5'd0;
      is_response  <= 1'b0;
      emit_idx     <= '0;
    end else begin
      if (ctl.count_clear) begin
        byte_count <= 5'd0;
      end else if (ctl.frame_start) begin
        byte_count <= 5'd1;
      end else if (ctl.collect) begin
        byte_count <= byte_count + 5'd1;
      end
      if (ctl.frame_start) begin
        target_count <= new_target;
        is_response  <= (cls == htfp_pkg::CC_RESP);
      end else if (ctl.irlen_load) begin
        target_count <= 5'(cur_byte[2:0]) + 5'd1;
      end
      if (ctl.emit_start) begin
        emit_idx <= '0;
      end else if (ctl.emit_step) begin
        emit_idx <= emit_idx + IDX_W'(1);
      end
    end
  end

  // frame payload: command, store and IR code
  always_ff @(posedge clk) begin
    if (ctl.frame_start) begin
      cmd_reg        <= cur_byte;
      frame_store[0] <= cur_byte;
      ir_acc         <= 32'd0;
    end else if (ctl.collect) begin
      if (byte_count < CAP5) begin
        frame_store[byte_count[IDX_W-1:0]] <= cur_byte;
      end
      ir_acc <= {ir_acc[23:0], cur_byte};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_sel != htfp_pkg::OS_NONE) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.out_sel)
      htfp_pkg::OS_BADCMD: begin
        m_tuser   <= htfp_pkg::STAT_BADCMD;
        o_command <= cur_byte;
        o_data    <= cur_byte;
        o_index   <= 4'd0;
        o_ir      <= 32'd0;
        m_tlast   <= 1'b1;
      end
      htfp_pkg::OS_BADIR: begin
        m_tuser   <= htfp_pkg::STAT_BADIR;
        o_command <= htfp_pkg::CMD_IR;
        o_data    <= cur_byte;
        o_index   <= 4'd1;
        o_ir      <= 32'd0;
        m_tlast   <= 1'b1;
      end
      htfp_pkg::OS_TRUNC: begin
        m_tuser   <= htfp_pkg::STAT_TRUNC;
        o_command <= cmd_reg;
        o_data    <= 8'd0;
        o_index   <= byte_count[3:0];
        o_ir      <= 32'd0;
        m_tlast   <= 1'b1;
      end
      htfp_pkg::OS_FRAME: begin
        m_tuser   <= is_response ? htfp_pkg::STAT_RESP : htfp_pkg::STAT_NOTE;
        o_command <= cmd_reg;
        o_data    <= frame_store[emit_idx];
        o_index   <= 4'(emit_idx);
        o_ir      <= ir_frame ? ir_acc : 32'd0;
        m_tlast   <= emit_last;
      end
      default: ;
    endcase
  end

  assign m_tdata = {4'd0, o_ir, o_index, o_data, o_command};

`ifndef NO_ASSERTIONS
  // run index stays inside the frame while emitting
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    ctl.emit_step |-> (target_count != 5'd0) && (5'(emit_idx) < target_count))
    else $error("emit index outside frame");

  // error and truncation results always close their run
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != htfp_pkg::STAT_RESP) && (m_tuser != htfp_pkg::STAT_NOTE)
      |-> m_tlast)
    else $error("single result without last");

  // byte count never passes the frame cap
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CAP5)
    else $error("byte count above cap");

  // an idle tick drops the pending nibble
  a_idle_nib: assert property (@(posedge clk) disable iff (rst)
    ctl.nib_clear |=> !nibble_pending)
    else $error("nibble pending after idle tick");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/htfp_ctrl.sv =====
//------------------------------------------------------------------------------
// htfp_ctrl
// Parser state machine: sequences frames and issues datapath commands.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htfp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic               s_tuser,
  input  wire htfp_pkg::dp_stat_t st,
  output htfp_pkg::ctl_cmd_t      ctl
);

  htfp_pkg::parse_state_t state, state_next;

  logic accept;
  logic is_idle;
  logic byte_done;

  assign s_tready  = (state != htfp_pkg::PS_EMIT) && st.out_free;
  assign accept    = s_tvalid && s_tready;
  assign is_idle   = (s_tuser == htfp_pkg::KIND_IDLE);
  assign byte_done = accept && !is_idle && st.nib_pending && (state != htfp_pkg::PS_DISCARD);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htfp_pkg::PS_AWAIT;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (accept && is_idle) begin
      state_next = htfp_pkg::PS_AWAIT;
    end else begin
      case (state)
        htfp_pkg::PS_AWAIT: begin
          if (byte_done) begin
            case (st.cmd_cls)
              htfp_pkg::CC_BAD: state_next = htfp_pkg::PS_DISCARD;
              htfp_pkg::CC_IR:  state_next = htfp_pkg::PS_IRLEN;
              default: state_next = st.single ? htfp_pkg::PS_EMIT : htfp_pkg::PS_COLLECT;
            endcase
          end
        end
        htfp_pkg::PS_IRLEN: begin
          if (byte_done) begin
            state_next = st.len_ok ? htfp_pkg::PS_COLLECT : htfp_pkg::PS_DISCARD;
          end
        end
        htfp_pkg::PS_COLLECT: begin
          if (byte_done && st.frame_done) begin
            state_next = htfp_pkg::PS_EMIT;
          end
        end
        htfp_pkg::PS_EMIT: begin
          if (st.out_free && st.emit_last) begin
            state_next = htfp_pkg::PS_AWAIT;
          end
        end
        default: state_next = state;
      endcase
    end
  end

  // datapath commands
  always_comb begin
    ctl         = '0;
    ctl.out_sel = htfp_pkg::OS_NONE;
    if (accept && is_idle) begin
      ctl.nib_clear   = 1'b1;
      ctl.count_clear = 1'b1;
      if (state == htfp_pkg::PS_COLLECT || state == htfp_pkg::PS_IRLEN) begin
        ctl.out_sel = htfp_pkg::OS_TRUNC;
      end
    end else begin
      ctl.nib_take = accept && (state != htfp_pkg::PS_DISCARD);
      case (state)
        htfp_pkg::PS_AWAIT: begin
          if (byte_done) begin
            ctl.frame_start = 1'b1;
            case (st.cmd_cls)
              htfp_pkg::CC_BAD: begin
                ctl.out_sel     = htfp_pkg::OS_BADCMD;
                ctl.count_clear = 1'b1;
              end
              htfp_pkg::CC_IR: ;
              default: ctl.emit_start = st.single;
            endcase
          end
        end
        htfp_pkg::PS_IRLEN: begin
          if (byte_done) begin
            if (st.len_ok) begin
              ctl.irlen_load = 1'b1;
            end else begin
              ctl.out_sel     = htfp_pkg::OS_BADIR;
              ctl.count_clear = 1'b1;
            end
          end
        end
        htfp_pkg::PS_COLLECT: begin
          if (byte_done) begin
            ctl.collect    = 1'b1;
            ctl.emit_start = st.frame_done;
          end
        end
        htfp_pkg::PS_EMIT: begin
          if (st.out_free) begin
            ctl.out_sel     = htfp_pkg::OS_FRAME;
            ctl.emit_step   = 1'b1;
            ctl.count_clear = st.emit_last;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // no input is taken while a frame run is going out
  a_emit_block: assert property (@(posedge clk) disable iff (rst)
    (state == htfp_pkg::PS_EMIT) |-> !accept)
    else $error("input accepted during emit");

  // a frame run starts only from a completed byte
  a_emit_entry: assert property (@(posedge clk) disable iff (rst)
    (state != htfp_pkg::PS_EMIT) && (state_next == htfp_pkg::PS_EMIT) |-> byte_done)
    else $error("emit entered without a byte");

  // an idle tick always lands in await command
  a_idle_await: assert property (@(posedge clk) disable iff (rst)
    accept && is_idle |=> (state == htfp_pkg::PS_AWAIT))
    else $error("idle tick did not return to await");
`endif

endmodule

`default_nettype wire
